/* rtl/mpd_pkg.sv */
// shared types and constants of the maglev pd controller
// no dependencies, imported by every rtl module of the block
package mpd_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned SumW     = 13;
  localparam int unsigned ErrW     = 11;
  localparam int unsigned DiffW    = 12;
  localparam int unsigned GainW    = 8;
  localparam int unsigned ProdW    = 21;
  localparam int unsigned DriveW   = 22;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned DivSteps = ErrW;
  localparam int unsigned CntW     = $clog2(DivSteps + 1);

  // divide by five: n * 52429 >> 18 is exact for n below 43690
  localparam logic [15:0] RecipFive  = 16'd52429;
  localparam int unsigned RecipShift = 18;

  localparam logic [7:0]          PotScale     = 8'd182;
  localparam logic [SampleW-1:0]  PotFull      = 10'd1023;
  localparam logic [SampleW-1:0]  SetpointBase = 10'd508;
  localparam logic [SampleW-1:0]  SetpointKick = 10'd559;
  localparam logic [SampleW-1:0]  RestLimit    = 10'd2;
  localparam logic [SampleW-1:0]  StuckLimit   = 10'd290;
  localparam logic [DutyW-1:0]    StuckDrive   = 8'd40;
  localparam logic signed [DriveW-1:0] DriveMax = 22'sd255;
  localparam logic signed [DriveW-1:0] DriveMin = -22'sd255;

  localparam logic [GainW-1:0] PropDivReset  = 8'd3;
  localparam logic [GainW-1:0] DerivGainReset = 8'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_DIV   = 2'd0,
    CFG_DERIV_GAIN = 2'd1
  } mpd_cfg_idx_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } mpd_back_state_e;

  // one classified sample set, handed from front to back
  typedef struct packed {
    logic signed [ErrW-1:0] err;
    logic [SampleW-1:0]     field;
    logic                   stuck;
  } mpd_item_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } mpd_q_status_t;

endpackage

/* rtl/mpd_front.sv */
// front end: accepts sample beats, averages sensors, maps setpoint, forms error
// depends on mpd_pkg
module mpd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [mpd_pkg::SampleW-1:0] sensor_a_i,
  input  logic [mpd_pkg::SampleW-1:0] sensor_b_i,
  input  logic [mpd_pkg::SampleW-1:0] sensor_c_i,
  input  logic [mpd_pkg::SampleW-1:0] sensor_d_i,
  input  logic [mpd_pkg::SampleW-1:0] sensor_e_i,
  input  logic [mpd_pkg::SampleW-1:0] pot_sample_i,
  input  mpd_pkg::mpd_q_status_t     q_status_i,
  output logic                       push_o,
  output mpd_pkg::mpd_item_t         item_o
);
  import mpd_pkg::*;

  logic               s1_valid_q, s1_valid_d;
  logic [SampleW-1:0] field_q, field_d;
  logic [7:0]         pot_off_q, pot_off_d;
  logic               accept;

  logic [SumW-1:0]    sum;
  logic [SumW+15:0]   sum_scaled;
  logic [17:0]        pot_prod;
  logic [7:0]         pot_q_est;
  logic [SampleW:0]   pot_rem;

  logic [SampleW-1:0]     setpoint;
  logic signed [ErrW-1:0] err;

  assign push_o     = s1_valid_q && !q_status_i.full;
  assign in_stall_o = s1_valid_q && q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  // sum / 5 by reciprocal multiply
  always_comb begin
    sum = SumW'(sensor_a_i) + SumW'(sensor_b_i) + SumW'(sensor_c_i)
        + SumW'(sensor_d_i) + SumW'(sensor_e_i);
    sum_scaled = (SumW+16)'(sum) * (SumW+16)'(RecipFive);
    field_d    = sum_scaled[RecipShift +: SampleW];
  end

  // pot * 182 / 1023: estimate with >> 10, remainder fix-up of at most one
  always_comb begin
    pot_prod  = 18'(pot_sample_i) * 18'(PotScale);
    pot_q_est = pot_prod[17:10];
    pot_rem   = (SampleW+1)'(pot_prod[9:0]) + (SampleW+1)'(pot_q_est);
    pot_off_d = (pot_rem >= (SampleW+1)'(PotFull)) ? pot_q_est + 8'd1 : pot_q_est;
  end

  always_comb begin
    s1_valid_d = accept ? 1'b1 : (push_o ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      field_q   <= field_d;
      pot_off_q <= pot_off_d;
    end
  end

  // magnet resting on the sensor gets a fixed kick setpoint
  always_comb begin
    setpoint     = (field_q <= RestLimit) ? SetpointKick
                                          : SampleW'(pot_off_q) + SetpointBase;
    err          = $signed(ErrW'(setpoint)) - $signed(ErrW'(field_q));
    item_o.err   = err;
    item_o.field = field_q;
    item_o.stuck = (field_q >= StuckLimit);
  end

endmodule

/* rtl/mpd_queue.sv */
// two-entry queue between front and back
// depends on mpd_pkg
module mpd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  mpd_pkg::mpd_item_t     item_i,
  input  logic                   pop_i,
  output mpd_pkg::mpd_item_t     item_o,
  output mpd_pkg::mpd_q_status_t status_o
);
  import mpd_pkg::*;

  mpd_item_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    status_o.full  = (count_q == 2'd2);
    status_o.empty = (count_q == 2'd0);
    item_o         = entry_q[rd_ptr_q];
    wr_ptr_d       = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d       = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d        = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> count_q != 2'd0)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push_i |-> count_q != 2'd2)
    else $error("push into full queue");

endmodule

/* rtl/mpd_back.sv */
// back end: serial divide for p term, d term multiply, saturation, stuck override, output register
// depends on mpd_pkg
module mpd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpd_pkg::mpd_q_status_t     q_status_i,
  input  mpd_pkg::mpd_item_t         item_i,
  output logic                       pop_o,
  input  logic [mpd_pkg::GainW-1:0]  divisor_i,
  input  logic [mpd_pkg::GainW-1:0]  gain_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [mpd_pkg::DutyW-1:0]  duty_o,
  output logic                       reverse_o,
  output logic [mpd_pkg::SampleW-1:0] field_avg_o
);
  import mpd_pkg::*;

  mpd_back_state_e state_q, state_d;

  logic                    out_valid_q, out_valid_d;
  logic [DutyW-1:0]        duty_q;
  logic                    reverse_q;
  logic [SampleW-1:0]      field_out_q;

  logic signed [ErrW-1:0]  prev_q;
  logic                    neg_q;
  logic                    stuck_q;
  logic [SampleW-1:0]      field_q;
  logic [ErrW-1:0]         quo_q;
  logic [GainW-1:0]        rem_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [ProdW-1:0] prod_q;

  logic                    load_out;
  logic                    out_free;
  logic [ErrW-1:0]         err_mag;
  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod_d;
  logic [GainW:0]          shifted;
  logic                    fits;
  logic signed [DiffW-1:0] p_term;
  logic signed [DriveW-1:0] drive;
  logic signed [DriveW-1:0] drive_sat;
  logic [DutyW-1:0]        duty_d;
  logic                    reverse_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (!q_status_i.empty) state_d = B_DIV;
      B_DIV:   if (cnt_q == CntW'(1)) state_d = B_DONE;
      B_DONE:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    out_free    = !out_valid_q || !out_stall_i;
    pop_o       = (state_q == B_IDLE) && !q_status_i.empty;
    load_out    = (state_q == B_DONE) && out_free;
    out_valid_d = load_out ? 1'b1 : ((out_valid_q && !out_stall_i) ? 1'b0 : out_valid_q);
  end

  // datapath
  always_comb begin
    err_mag = item_i.err[ErrW-1] ? ErrW'(-item_i.err) : ErrW'(item_i.err);
    diff    = DiffW'(item_i.err) - DiffW'(prev_q);
    prod_d  = ProdW'(diff) * $signed(ProdW'({1'b0, gain_i}));
    shifted = {rem_q, quo_q[ErrW-1]};
    fits    = shifted >= {1'b0, divisor_i};
    p_term  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    drive   = DriveW'(p_term) + DriveW'(prod_q);
    if (drive > DriveMax) begin
      drive_sat = DriveMax;
    end else if (drive < DriveMin) begin
      drive_sat = DriveMin;
    end else begin
      drive_sat = drive;
    end
    if (stuck_q) begin
      duty_d    = StuckDrive;
      reverse_d = 1'b0;
    end else begin
      reverse_d = drive_sat[DriveW-1];
      duty_d    = reverse_d ? DutyW'(-drive_sat) : DutyW'(drive_sat);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      prev_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        prev_q <= item_i.err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      neg_q   <= item_i.err[ErrW-1];
      stuck_q <= item_i.stuck;
      field_q <= item_i.field;
      quo_q   <= err_mag;
      rem_q   <= '0;
      cnt_q   <= CntW'(DivSteps);
      prod_q  <= prod_d;
    end else if (state_q == B_DIV) begin
      rem_q <= fits ? GainW'(shifted - {1'b0, divisor_i}) : GainW'(shifted);
      quo_q <= {quo_q[ErrW-2:0], fits};
      cnt_q <= cnt_q - CntW'(1);
    end
    if (load_out) begin
      duty_q      <= duty_d;
      reverse_q   <= reverse_d;
      field_out_q <= field_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_q;
  assign reverse_o   = reverse_q;
  assign field_avg_o = field_out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   state_q == B_DIV |-> cnt_q != '0)
    else $error("divide running with no steps left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   load_out && stuck_q |=> duty_q == StuckDrive && !reverse_q)
    else $error("stuck magnet drive not forced");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q && reverse_q |-> duty_q != '0)
    else $error("reverse flagged with zero duty");

endmodule

/* rtl/maglev_pd_controller_top.sv */
// top level of the maglev pd controller: config registers, front, queue, back
// depends on mpd_pkg, mpd_front, mpd_queue, mpd_back
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | sensor_a_i..sensor_e_i, pot_sample_i
//  out     | output    | out_valid_o / out_stall_i | duty_o, reverse_o, field_avg_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// an item sits in the front register (average and scaled pot offset; setpoint and error
// are formed on the way into the queue) and then in the queue, then passes the back:
// a pop, 11 steps of the restoring divider for the proportional term (one quotient
// bit a cycle), then add and saturate. the pop is made while the item is in the queue.
// the back's serial divider sets the sustained rate: the back pops a new item only when
// idle, once its last result has been loaded into the output register.
// the two-entry queue and the output register let the front keep taking beats while
// a result waits on out_stall_i. reset clears the pipeline and the previous error,
// and loads divisor 3 and gain 10. cfg writes are always taken (ready tied high).
module maglev_pd_controller_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // sample channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mpd_pkg::SampleW-1:0] sensor_a_i,
  input  logic [mpd_pkg::SampleW-1:0] sensor_b_i,
  input  logic [mpd_pkg::SampleW-1:0] sensor_c_i,
  input  logic [mpd_pkg::SampleW-1:0] sensor_d_i,
  input  logic [mpd_pkg::SampleW-1:0] sensor_e_i,
  input  logic [mpd_pkg::SampleW-1:0] pot_sample_i,
  // drive channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mpd_pkg::DutyW-1:0]   duty_o,
  output logic                        reverse_o,
  output logic [mpd_pkg::SampleW-1:0] field_avg_o,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [mpd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mpd_pkg::GainW-1:0]   cfg_data_i
);
  import mpd_pkg::*;

  logic [GainW-1:0] prop_div_q;
  logic [GainW-1:0] deriv_gain_q;
  logic [GainW-1:0] divisor_eff;
  logic             cfg_write;

  mpd_item_t     front_item;
  mpd_item_t     queue_item;
  mpd_q_status_t q_status;
  logic          push;
  logic          pop;

  // config writes, unknown indexes are dropped
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_div_q   <= PropDivReset;
      deriv_gain_q <= DerivGainReset;
    end else if (cfg_write) begin
      case (cfg_index_i)
        CFG_PROP_DIV:   prop_div_q   <= cfg_data_i;
        CFG_DERIV_GAIN: deriv_gain_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  // a zero divisor acts as one
  assign divisor_eff = (prop_div_q == '0) ? GainW'(1) : prop_div_q;

  mpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sensor_a_i   (sensor_a_i),
    .sensor_b_i   (sensor_b_i),
    .sensor_c_i   (sensor_c_i),
    .sensor_d_i   (sensor_d_i),
    .sensor_e_i   (sensor_e_i),
    .pot_sample_i (pot_sample_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .item_o       (front_item)
  );

  mpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (front_item),
    .pop_i    (pop),
    .item_o   (queue_item),
    .status_o (q_status)
  );

  mpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .item_i      (queue_item),
    .pop_o       (pop),
    .divisor_i   (divisor_eff),
    .gain_i      (deriv_gain_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .duty_o      (duty_o),
    .reverse_o   (reverse_o),
    .field_avg_o (field_avg_o)
  );

endmodule

/* tb/maglev_pd_controller_top_tb.sv */
// testbench of maglev_pd_controller_top: directed and random sample sets, checked per beat
// against an in-bench model of the pd drive law held by a small scoreboard class
// depends on mpd_pkg and the maglev_pd_controller_top rtl
`timescale 1ns / 1ps

module maglev_pd_controller_top_tb;
  import mpd_pkg::*;

  // drive law constants, kept as plain ints so all math stays signed
  localparam int NumSensors  = 5;
  localparam int PotGain     = 182;
  localparam int PotRange    = 1023;
  localparam int SetBase     = 508;
  localparam int SetKick     = 559;
  localparam int RestMax     = 2;
  localparam int StuckMin    = 290;
  localparam int StuckForce  = 40;
  localparam int DriveLimit  = 255;
  localparam int DrainCycles = 20;
  localparam int ItemsPerSet = 210;
  localparam int NumGainSets = 8;

  // register indexes the block does not decode
  localparam logic [CfgIdxW-1:0] CfgIdxSpare2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpare3 = 2'd3;

  typedef struct packed {
    logic [SampleW-1:0] a;
    logic [SampleW-1:0] b;
    logic [SampleW-1:0] c;
    logic [SampleW-1:0] d;
    logic [SampleW-1:0] e;
    logic [SampleW-1:0] pot;
  } sample_set_t;

  typedef struct packed {
    logic [DutyW-1:0]   duty;
    logic               reverse;
    logic [SampleW-1:0] field_avg;
  } coil_drive_t;

  // holds the controller's gains and last error, and the drives still owed
  class drive_scoreboard;
    int prop_div;
    int deriv_gain;
    int last_err;
    int errors;
    coil_drive_t owed_drives[$];

    function new();
      prop_div   = int'(PropDivReset);
      deriv_gain = int'(DerivGainReset);
      last_err   = 0;
      errors     = 0;
    endfunction

    function void write_gain(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] data);
      if (idx == CFG_PROP_DIV) begin
        prop_div = int'(data);
      end else if (idx == CFG_DERIV_GAIN) begin
        deriv_gain = int'(data);
      end
    endfunction

    function coil_drive_t predict_drive(sample_set_t s);
      int field;
      int setpoint;
      int err;
      int divisor;
      int drive;
      coil_drive_t r;
      field = (int'(s.a) + int'(s.b) + int'(s.c) + int'(s.d) + int'(s.e)) / NumSensors;
      setpoint = int'(s.pot) * PotGain / PotRange + SetBase;
      // magnet resting on the base: kick it up with a fixed setpoint
      if (field <= RestMax) setpoint = SetKick;
      err = setpoint - field;
      divisor = (prop_div == 0) ? 1 : prop_div;
      drive = err / divisor + (err - last_err) * deriv_gain;
      last_err = err;
      // magnet stuck to the coil: release with a fixed drive
      if (field >= StuckMin) drive = StuckForce;
      if (drive > DriveLimit) drive = DriveLimit;
      if (drive < -DriveLimit) drive = -DriveLimit;
      r.reverse   = (drive < 0);
      r.duty      = DutyW'((drive < 0) ? -drive : drive);
      r.field_avg = SampleW'(field);
      return r;
    endfunction

    function void note_samples(sample_set_t s);
      owed_drives.push_back(predict_drive(s));
    endfunction

    function void check_drive(coil_drive_t got);
      coil_drive_t want;
      if (owed_drives.size() == 0) begin
        $display("%0t: drive beat with none owed, duty %0d reverse %0b field %0d",
                 $time, got.duty, got.reverse, got.field_avg);
        errors++;
        return;
      end
      want = owed_drives.pop_front();
      if (got.duty !== want.duty) begin
        $display("%0t: duty expected %0d actual %0d", $time, want.duty, got.duty);
        errors++;
      end
      if (got.reverse !== want.reverse) begin
        $display("%0t: reverse expected %0b actual %0b", $time, want.reverse, got.reverse);
        errors++;
      end
      if (got.field_avg !== want.field_avg) begin
        $display("%0t: field_avg expected %0d actual %0d",
                 $time, want.field_avg, got.field_avg);
        errors++;
      end
    endfunction

    function int pending();
      return owed_drives.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [SampleW-1:0] sensor_a_i;
  logic [SampleW-1:0] sensor_b_i;
  logic [SampleW-1:0] sensor_c_i;
  logic [SampleW-1:0] sensor_d_i;
  logic [SampleW-1:0] sensor_e_i;
  logic [SampleW-1:0] pot_sample_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [DutyW-1:0]   duty_o;
  logic               reverse_o;
  logic [SampleW-1:0] field_avg_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [GainW-1:0]   cfg_data_i;

  drive_scoreboard sb = new();

  // when set, neither side inserts gaps or stalls
  bit no_idle = 1'b0;

  maglev_pd_controller_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sensor_a_i   (sensor_a_i),
    .sensor_b_i   (sensor_b_i),
    .sensor_c_i   (sensor_c_i),
    .sensor_d_i   (sensor_d_i),
    .sensor_e_i   (sensor_e_i),
    .pot_sample_i (pot_sample_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .duty_o       (duty_o),
    .reverse_o    (reverse_o),
    .field_avg_o  (field_avg_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // cycles a side idles before its next beat
  function automatic int draw_wait();
    return no_idle ? 0 : int'($urandom_range(0, 5));
  endfunction

  function automatic sample_set_t make_set(int a, int b, int c, int d, int e, int pot);
    sample_set_t s;
    s.a   = SampleW'(a);
    s.b   = SampleW'(b);
    s.c   = SampleW'(c);
    s.d   = SampleW'(d);
    s.e   = SampleW'(e);
    s.pot = SampleW'(pot);
    return s;
  endfunction

  // random sample set, weighted toward the levitating range below the stuck limit
  function automatic sample_set_t random_set();
    sample_set_t s;
    int pick;
    int lo;
    int hi;
    pick = int'($urandom_range(0, 9));
    s.pot = SampleW'($urandom_range(0, 1023));
    if (pick < 2) begin
      // resting magnet, average around the rest limit
      lo = 0;
      hi = 5;
    end else if (pick < 7) begin
      // normal control range, average mostly below 290
      lo = 0;
      hi = int'($urandom_range(10, 560));
    end else if (pick == 7) begin
      // straddle the stuck limit
      lo = 280;
      hi = 300;
    end else begin
      // anything at all
      lo = 0;
      hi = 1023;
    end
    s.a = SampleW'($urandom_range(lo, hi));
    s.b = SampleW'($urandom_range(lo, hi));
    s.c = SampleW'($urandom_range(lo, hi));
    s.d = SampleW'($urandom_range(lo, hi));
    s.e = SampleW'($urandom_range(lo, hi));
    return s;
  endfunction

  // one sample beat; valid stays high across back-to-back beats
  task automatic send_samples(input sample_set_t s);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sensor_a_i   <= s.a;
    sensor_b_i   <= s.b;
    sensor_c_i   <= s.c;
    sensor_d_i   <= s.d;
    sensor_e_i   <= s.e;
    pot_sample_i <= s.pot;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_samples(s);
  endtask

  // one cfg beat; the caller drops valid after its last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [GainW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.write_gain(idx, data);
  endtask

  // both gains, then a write to an undecoded index that must change nothing
  task automatic set_gains(input int prop, input int gain);
    write_reg(CFG_PROP_DIV, GainW'(prop));
    write_reg(CFG_DERIV_GAIN, GainW'(gain));
    write_reg(($urandom_range(0, 1) != 0) ? CfgIdxSpare2 : CfgIdxSpare3,
              GainW'($urandom_range(0, 255)));
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending and wait until every owed drive has come back, then let the back settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // drive sink: a stall count is drawn ahead of each result and counted down
  // only while the result is offered, so stalls land right on valid beats
  initial begin : drive_sink
    int hold;
    coil_drive_t got;
    hold = draw_wait();
    out_stall_i <= (hold > 0);
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        got.duty      = duty_o;
        got.reverse   = reverse_o;
        got.field_avg = field_avg_o;
        sb.check_drive(got);
        hold = draw_wait();
        out_stall_i <= (hold > 0);
      end else if (out_valid_o === 1'b1 && hold > 0) begin
        hold--;
        out_stall_i <= (hold > 0);
      end
    end
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int prop;
    int gain;
    // every input known from time zero
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    sensor_a_i   <= '0;
    sensor_b_i   <= '0;
    sensor_c_i   <= '0;
    sensor_d_i   <= '0;
    sensor_e_i   <= '0;
    pot_sample_i <= '0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset gains: rest limit, stuck limit and field extremes
    send_samples(make_set(0, 0, 0, 0, 0, 0));               // resting, kick setpoint
    send_samples(make_set(2, 2, 2, 2, 2, 1023));            // average exactly at rest limit
    send_samples(make_set(3, 3, 3, 3, 3, 0));               // just above rest, lowest setpoint
    send_samples(make_set(14, 0, 0, 0, 0, 512));            // sum truncates down to 2
    send_samples(make_set(15, 0, 0, 0, 0, 512));            // sum divides to 3
    send_samples(make_set(289, 289, 289, 289, 289, 1023));  // last field before stuck
    send_samples(make_set(290, 290, 290, 290, 290, 0));     // first stuck field
    send_samples(make_set(1023, 1023, 1023, 1023, 1023, 1023));
    send_samples(make_set(1023, 0, 0, 0, 0, 0));
    send_samples(make_set(10'h2aa, 10'h2aa, 10'h2aa, 10'h2aa, 10'h2aa, 10'h155));
    send_samples(make_set(10'h155, 10'h155, 10'h155, 10'h155, 10'h155, 10'h2aa));
    send_samples(make_set(0, 0, 0, 0, 0, 1023));            // big positive jump, saturates
    send_samples(make_set(289, 289, 289, 289, 289, 0));     // big negative step, reverse
    send_samples(make_set(100, 200, 300, 400, 0, 777));
    drain();

    // zero divisor acts as one, no derivative
    set_gains(0, 0);
    send_samples(make_set(0, 0, 0, 0, 0, 0));
    send_samples(make_set(289, 289, 289, 289, 289, 0));
    send_samples(make_set(200, 200, 200, 200, 200, 1023));
    send_samples(make_set(5, 4, 3, 2, 1, 300));
    drain();

    // random part: gain extremes first, then random gains
    for (int g = 0; g < NumGainSets; g++) begin
      case (g)
        0: begin prop = 1;   gain = 0;   end
        1: begin prop = 255; gain = 255; end
        2: begin prop = 0;   gain = 1;   end
        3: begin prop = 1;   gain = 255; end
        4: begin prop = 255; gain = 0;   end
        default: begin
          prop = int'($urandom_range(0, 255));
          gain = int'($urandom_range(0, 255));
        end
      endcase
      // some sets run flat out on both sides
      no_idle = (g % 3 == 2);
      set_gains(prop, gain);
      for (int k = 0; k < ItemsPerSet; k++) begin
        send_samples(random_set());
      end
      // sender holds off until every drive is back, the block goes idle
      drain();
    end

    no_idle = 1'b0;
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
